FILE: rtl/tccw_pkg.sv
// Shared types, constants and helper functions of the text console cell writer.
`default_nettype none
package tccw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int ADDR_W  = 11;
	localparam int GRID_W  = $clog2(ROWS * COLUMNS);
	localparam int AFULL_W = (GRID_W > ADDR_W) ? GRID_W : ADDR_W;

	localparam int NUM_W   = 32;
	localparam int DIGIT_W = 4;
	localparam int DEPTH   = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	// quotient of a 32-bit value by ten
	localparam int QUO_W   = 29;
	localparam logic [NUM_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	localparam logic [7:0] COLOR_RESET = 8'h0F;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_A      = 8'h41;

	typedef enum logic [1:0] {
		CMD_PUT     = 2'd0,
		CMD_NEWLINE = 2'd1,
		CMD_NUMBER  = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_DIV,
		ST_STEP,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic conv_div;
		logic conv_step;
		logic emit_put;
		logic emit_digit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic       req_valid;
		logic [1:0] req_cmd;
		logic [1:0] req_radix;
		logic       out_free;
		logic       step_last;
		logic       ptr_zero;
	} sts_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] ch;
		if (d < 4'd10) begin
			ch = CHAR_ZERO + {4'd0, d};
		end else begin
			ch = CHAR_A + {4'd0, d} - 8'd10;
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tccw_channels.sv
// Valid/ready channel interfaces for console commands and cell writes.
`default_nettype none
interface tccw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  char_code;
	logic [7:0]  attribute;
	logic [31:0] number;
	logic [1:0]  radix_select;

	modport source (output valid, cmd, char_code, attribute, number, radix_select,
		input ready);
	modport sink (input valid, cmd, char_code, attribute, number, radix_select,
		output ready);
endinterface

interface tccw_cell_if;
	logic                        valid;
	logic                        ready;
	logic [tccw_pkg::ADDR_W-1:0] cell_address;
	logic [15:0]                 cell_value;
	logic                        last_cell;

	modport source (output valid, cell_address, cell_value, last_cell, input ready);
	modport sink (input valid, cell_address, cell_value, last_cell, output ready);
endinterface
`default_nettype wire

FILE: rtl/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: controller plus datapath.
`default_nettype none
// Usage:
//   req   - command transactions (cmd, char_code, attribute, number,
//           radix_select), valid/ready. One command is taken at a time.
//   cells - cell write transactions (cell_address, cell_value, last_cell),
//           valid/ready, driven from an output register.
//   cfg_we/cfg_wdata - write the default color used for digit cells; write
//           only while the block is idle.
// Timing: put character moves to a put state after acceptance and loads its
//   cell into the output register once that register is free; a newline
//   writes nothing. Print number converts one digit per cycle for hex and
//   binary; decimal alternates a divide state and a step state (the
//   divide-by-ten multiplier is registered before the remainder step),
//   then emits one digit cell per cycle while the output register is free.
// The next command is accepted as soon as the last cell of the previous one
//   is loaded into the output register, even if that cell still waits.
// Reset puts the cursor at row 0, column 0 and the color at 0x0F.
// A stalled receiver holds the output register and freezes emission.
module text_console_cell_writer_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [7:0]   cfg_wdata,
	tccw_req_if.sink     req,
	tccw_cell_if.source  cells
);
	import tccw_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequence each command
	tccw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// hold cursor, digits and the output register
	tccw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cells     (cells),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule
`default_nettype wire

FILE: rtl/tccw_ctrl.sv
// Controller state machine: sequences accept, digit conversion and cell emission.
`default_nettype none
module tccw_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  tccw_pkg::sts_t    sts,
	output tccw_pkg::ctl_t    ctl
);
	import tccw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.take = 1'b1;
				if (sts.req_valid) begin
					case (sts.req_cmd)
						CMD_PUT: state_d = ST_PUT;
						CMD_NUMBER: begin
							case (sts.req_radix)
								RADIX_DEC: state_d = ST_DIV;
								RADIX_HEX, RADIX_BIN: state_d = ST_STEP;
								default: state_d = ST_IDLE;
							endcase
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PUT: begin
				if (sts.out_free) begin
					ctl.emit_put = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DIV: begin
				ctl.conv_div = 1'b1;
				state_d      = ST_STEP;
			end
			ST_STEP: begin
				ctl.conv_step = 1'b1;
				if (sts.step_last) begin
					state_d = ST_EMIT;
				end else if (sts.req_radix == RADIX_DEC) begin
					state_d = ST_DIV;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit_digit = 1'b1;
					if (sts.ptr_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/tccw_dp.sv
// Datapath: cursor, color register, digit conversion, digit stack and output register.
`default_nettype none
module tccw_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [7:0]        cfg_wdata,
	tccw_req_if.sink          req,
	tccw_cell_if.source       cells,
	input  tccw_pkg::ctl_t    ctl,
	output tccw_pkg::sts_t    sts
);
	import tccw_pkg::*;

	logic [7:0]         color_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [7:0]         char_q;
	logic [7:0]         attr_q;
	logic [1:0]         radix_q;
	logic [NUM_W-1:0]   num_q;
	logic [QUO_W-1:0]   quo_q;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [DIGIT_W-1:0] digits_q [DEPTH];

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [15:0]          out_value_q;
	logic                 out_last_q;

	logic                 load;
	logic                 emit;
	logic                 row_last;
	logic                 col_last;
	logic [2*NUM_W-1:0]   product;
	logic [NUM_W-1:0]     quo_ten;
	logic [NUM_W-1:0]     rem_dec;
	logic [DIGIT_W-1:0]   step_digit;
	logic [NUM_W-1:0]     step_num;
	logic [AFULL_W-1:0]   addr_full;

	assign load     = ctl.take && req.valid;
	assign emit     = ctl.emit_put || ctl.emit_digit;
	assign row_last = (row_q == ROW_W'(ROWS - 1));
	assign col_last = (col_q == COL_W'(COLUMNS - 1));

	assign req.ready = ctl.take;

	assign sts.req_valid = req.valid;
	assign sts.req_cmd   = ctl.take ? req.cmd : CMD_NUMBER;
	assign sts.req_radix = ctl.take ? req.radix_select : radix_q;
	assign sts.out_free  = !out_valid_q || cells.ready;
	assign sts.ptr_zero  = (ptr_q == '0);

	// divide by ten through the reciprocal, remainder by shift-add
	assign product = num_q * RECIP_TEN;
	assign quo_ten = ({3'd0, quo_q} << 3) + ({3'd0, quo_q} << 1);
	assign rem_dec = num_q - quo_ten;

	always_comb begin
		case (radix_q)
			RADIX_DEC: begin
				step_digit = rem_dec[DIGIT_W-1:0];
				step_num   = {3'd0, quo_q};
			end
			RADIX_HEX: begin
				step_digit = num_q[3:0];
				step_num   = {4'd0, num_q[NUM_W-1:4]};
			end
			default: begin
				step_digit = {3'd0, num_q[0]};
				step_num   = {1'b0, num_q[NUM_W-1:1]};
			end
		endcase
	end
	assign sts.step_last = (step_num == '0);

	assign addr_full = AFULL_W'(row_q) * AFULL_W'(COLUMNS) + AFULL_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	// cursor: newline at accept, advance on every cell write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load && req.cmd == CMD_NEWLINE) begin
			col_q <= '0;
			row_q <= row_last ? '0 : row_q + 1'b1;
		end else if (emit) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// item payload and conversion registers
	always_ff @(posedge clk) begin
		if (load) begin
			char_q  <= req.char_code;
			attr_q  <= req.attribute;
			radix_q <= req.radix_select;
			num_q   <= req.number;
		end else if (ctl.conv_step) begin
			num_q <= step_num;
		end
		if (ctl.conv_div) begin
			quo_q <= product[2*NUM_W-1:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			ptr_q    <= '0;
		end else if (load) begin
			wr_idx_q <= '0;
		end else if (ctl.conv_step) begin
			wr_idx_q <= wr_idx_q + 1'b1;
			ptr_q    <= wr_idx_q;
		end else if (ctl.emit_digit) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.conv_step) begin
			digits_q[wr_idx_q] <= step_digit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (cells.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q <= addr_full[ADDR_W-1:0];
			if (ctl.emit_put) begin
				out_value_q <= {attr_q, char_q};
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= {color_q, digit_char(digits_q[ptr_q])};
				out_last_q  <= (ptr_q == '0);
			end
		end
	end

	assign cells.valid        = out_valid_q;
	assign cells.cell_address = out_addr_q;
	assign cells.cell_value   = out_value_q;
	assign cells.last_cell    = out_last_q;

endmodule
`default_nettype wire

FILE: tb/tccw_cell_checker.sv
// Cursor predictor and cell-write scoreboard for the text console cell writer.
`timescale 1ns / 1ps
module tccw_cell_checker (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire [7:0] cfg_wdata,
	tccw_req_if       req,
	tccw_cell_if      cells,
	output int        fail_count,
	output int        cells_waiting
);
	import tccw_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [15:0]       value;
		logic              last;
	} cell_write_t;

	cell_write_t       cells_due[$];
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [7:0]        digit_color;
	int                mismatches;

	// queue one cell at the cursor, then advance with column and row wrap
	task automatic queue_cell(input logic [7:0] attr, input logic [7:0] ch,
		input logic last);
		cell_write_t w;
		int          col;
		int          row;
		col       = cursor_col;
		row       = cursor_row;
		w.address = ADDR_W'(row * COLUMNS + col);
		w.value   = {attr, ch};
		w.last    = last;
		cells_due.push_back(w);
		col++;
		if (col >= COLUMNS) begin
			col = 0;
			row++;
		end
		if (row >= ROWS) begin
			col = 0;
			row = 0;
		end
		cursor_col = COL_W'(col);
		cursor_row = ROW_W'(row);
	endtask

	task automatic queue_number(input logic [31:0] value, input logic [1:0] rsel);
		logic [31:0]        base;
		logic [31:0]        rest;
		logic [DIGIT_W-1:0] digits[DEPTH];
		logic [7:0]         ch;
		int                 count;
		int                 k;
		case (rsel)
			RADIX_DEC: base = 32'd10;
			RADIX_HEX: base = 32'd16;
			RADIX_BIN: base = 32'd2;
			default:   base = 32'd0;
		endcase
		if (base != 0) begin
			rest  = value;
			count = 0;
			do begin
				digits[count] = DIGIT_W'(rest % base);
				rest          = rest / base;
				count++;
			end while (rest != 0 && count < DEPTH);
			for (k = 0; k < count; k++) begin
				if (digits[count-1-k] < 10)
					ch = CHAR_ZERO + 8'(digits[count-1-k]);
				else
					ch = CHAR_A + 8'(digits[count-1-k]) - 8'd10;
				queue_cell(digit_color, ch, k == count - 1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cell_write_t want;
		int          row;
		if (!arst_n) begin
			cursor_col  = '0;
			cursor_row  = '0;
			digit_color = COLOR_RESET;
			mismatches  = 0;
			cells_due.delete();
			fail_count    <= 0;
			cells_waiting <= 0;
		end else begin
			if (cfg_we)
				digit_color = cfg_wdata;

			if (cells.valid && cells.ready) begin
				if (cells_due.size() == 0) begin
					$error("unexpected cell write: address %0d value %h",
						cells.cell_address, cells.cell_value);
					mismatches++;
				end else begin
					want = cells_due.pop_front();
					if (cells.cell_address !== want.address) begin
						$error("cell_address: expected %0d, actual %0d",
							want.address, cells.cell_address);
						mismatches++;
					end
					if (cells.cell_value !== want.value) begin
						$error("cell_value: expected %h, actual %h",
							want.value, cells.cell_value);
						mismatches++;
					end
					if (cells.last_cell !== want.last) begin
						$error("last_cell: expected %0d, actual %0d",
							want.last, cells.last_cell);
						mismatches++;
					end
				end
			end

			if (req.valid && req.ready) begin
				case (req.cmd)
					CMD_PUT: queue_cell(req.attribute, req.char_code, 1'b1);
					CMD_NEWLINE: begin
						row        = cursor_row + 1;
						cursor_col = '0;
						cursor_row = (row >= ROWS) ? '0 : ROW_W'(row);
					end
					CMD_NUMBER: queue_number(req.number, req.radix_select);
					default: ;
				endcase
			end

			fail_count    <= mismatches;
			cells_waiting <= cells_due.size();
		end
	end

endmodule

FILE: tb/tb_text_console_cell_writer_unit.sv
// Testbench top: stimulus, receiver stalls and verdict for the console cell writer.
`timescale 1ns / 1ps
module tb_text_console_cell_writer_unit;
	import tccw_pkg::*;

	// codes the block must ignore
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam logic [1:0] RADIX_UNUSED = 2'd3;

	// worst command is a 32-digit binary print
	localparam int SETTLE_CYCLES   = 120;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 65;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	// idle_enable turns random gaps on both sides on or off;
	// stall_request asks the receiver for one long hold-off
	bit idle_enable;
	bit stall_request;
	int fail_count;
	int cells_waiting;

	tccw_req_if  cmd_ch ();
	tccw_cell_if cell_ch ();

	text_console_cell_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (cmd_ch),
		.cells     (cell_ch)
	);

	tccw_cell_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req           (cmd_ch),
		.cells         (cell_ch),
		.fail_count    (fail_count),
		.cells_waiting (cells_waiting)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hard stop: several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: drop ready at random, or hold it low for a long stretch on
	// request so that the output register stays full and the block backs up.
	initial begin
		cell_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				cell_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				cell_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 15);
			end
		end
	end

	// Offer one command and hold it until the block takes it. Valid stays
	// high on return so that back-to-back transactions need no extra step.
	task automatic send_command(input logic [1:0] code, input logic [7:0] ch,
		input logic [7:0] attr, input logic [31:0] value, input logic [1:0] rsel);
		while (idle_enable && $urandom_range(0, 99) < 15) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.cmd          <= code;
		cmd_ch.char_code    <= ch;
		cmd_ch.attribute    <= attr;
		cmd_ch.number       <= value;
		cmd_ch.radix_select <= rsel;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// Drop valid, wait for every expected cell, then give a newline or an
	// ignored command time to finish inside the block.
	task automatic settle;
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (cells_waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_digit_color(input logic [7:0] color);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= color;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly legal commands with random payloads; a few unused codes mixed in.
	// Numbers lean toward short values but full-width and extreme ones appear.
	task automatic send_random_command;
		int          pick;
		logic [1:0]  code;
		logic [1:0]  rsel;
		logic [31:0] value;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			code = CMD_PUT;
		else if (pick < 55)
			code = CMD_NEWLINE;
		else if (pick < 95)
			code = CMD_NUMBER;
		else
			code = CMD_UNUSED;
		rsel = ($urandom_range(0, 99) < 4) ? RADIX_UNUSED : 2'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0: value = $urandom;
			1: value = $urandom >> $urandom_range(0, 31);
			2: value = $urandom_range(0, 20);
			default: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		send_command(code, 8'($urandom), 8'($urandom), value, rsel);
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= 8'h00;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.cmd          <= CMD_PUT;
		cmd_ch.char_code    <= 8'h00;
		cmd_ch.attribute    <= 8'h00;
		cmd_ch.number       <= 32'h0;
		cmd_ch.radix_select <= RADIX_DEC;
		idle_enable = 1'b1;
		stall_request = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset color: byte extremes, every command,
		// every radix, zero, full-width values, and the ignored codes.
		send_command(CMD_PUT, 8'h00, 8'h00, 32'h0, RADIX_DEC);
		send_command(CMD_PUT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, RADIX_UNUSED);
		send_command(CMD_PUT, 8'h80, 8'h5A, 32'h0, RADIX_HEX);
		send_command(CMD_NEWLINE, 8'h41, 8'h07, 32'h0, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'h0, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'h0, RADIX_HEX);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'h0, RADIX_BIN);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'hFFFF_FFFF, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'hFFFF_FFFF, RADIX_HEX);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'hFFFF_FFFF, RADIX_BIN);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'h8000_0000, RADIX_BIN);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'd1, RADIX_BIN);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'd9, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'd10, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'd1_000_000_000, RADIX_DEC);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'h1234_5678, RADIX_HEX);
		send_command(CMD_NUMBER, 8'h00, 8'h00, 32'hABCD_EF09, RADIX_HEX);
		send_command(CMD_NUMBER, 8'hFF, 8'hFF, 32'hFFFF_FFFF, RADIX_UNUSED);
		send_command(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, RADIX_BIN);
		send_command(CMD_NEWLINE, 8'h00, 8'h00, 32'h0, RADIX_DEC);
		send_command(CMD_PUT, 8'h7F, 8'h1E, 32'h0, RADIX_DEC);

		// Phase with the lowest color.
		set_digit_color(8'h00);
		repeat (ITEMS_PER_PHASE) send_random_command();

		// Phase with the highest color, no idling at all, and one long
		// receiver hold-off while commands keep coming.
		set_digit_color(8'hFF);
		idle_enable = 1'b0;
		stall_request = 1'b1;
		repeat (ITEMS_PER_PHASE) send_random_command();

		// Phase with a random color and idling back on.
		set_digit_color(8'($urandom));
		idle_enable = 1'b1;
		repeat (ITEMS_PER_PHASE) send_random_command();

		// Drain the last cells, then let any stray write show up.
		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
